@@ rtl/rbwb_pkg.sv @@
package rbwb_pkg;

  // Build constants
  localparam int LAYER_COUNT = 12;
  localparam int COORD_BITS  = 12;

  // Field widths
  localparam int TEXEL_W    = 12;
  localparam int CENTER_W   = 13;
  localparam int RADIUS_W   = 12;
  localparam int LAYER_W    = 4;
  localparam int WEIGHT_W   = 8;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Datapath widths: magnitude of a coordinate difference, its square, the
  // radicand padded to an even width, and the root.
  localparam int MAG_W  = ((COORD_BITS > CENTER_W - 1) ? COORD_BITS : CENTER_W - 1) + 1;
  localparam int DIFF_W = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = MAG_W + 1;
  localparam int REM_W  = ROOT_W + 2;
  localparam int DIST_W = ROOT_W + 1;
  localparam int RING_W = DIST_W - 1;

  localparam logic [MAG_W-1:0] COORD_MASK = MAG_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic [STEP_W-1:0]   STEP_CORE  = STEP_W'(25);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_BRUSH_RADIUS = 2'd2,
    REG_PAINT_LAYER  = 2'd3
  } cfg_reg_t;

  // Step of soft ring r: floor(25 / (2(r+1))); zero from ring twelve on.
  function automatic logic [STEP_W-1:0] ring_step(input logic [RING_W-1:0] ring);
    logic [STEP_W-1:0] s;
    case (ring)
      RING_W'(0):  s = STEP_W'(12);
      RING_W'(1):  s = STEP_W'(6);
      RING_W'(2):  s = STEP_W'(4);
      RING_W'(3):  s = STEP_W'(3);
      RING_W'(4):  s = STEP_W'(2);
      RING_W'(5):  s = STEP_W'(2);
      RING_W'(6):  s = STEP_W'(1);
      RING_W'(7):  s = STEP_W'(1);
      RING_W'(8):  s = STEP_W'(1);
      RING_W'(9):  s = STEP_W'(1);
      RING_W'(10): s = STEP_W'(1);
      RING_W'(11): s = STEP_W'(1);
      default:     s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/rbwb_if.sv @@
interface rbwb_in_if import rbwb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TEXEL_W-1:0]  texel_x;
  logic [TEXEL_W-1:0]  texel_y;
  logic [LAYER_W-1:0]  layer_index;
  logic [WEIGHT_W-1:0] weight_in;

  modport source (output valid, texel_x, texel_y, layer_index, weight_in, input ready);
  modport sink   (input valid, texel_x, texel_y, layer_index, weight_in, output ready);
endinterface

interface rbwb_out_if import rbwb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight_out;
  logic [STEP_W-1:0]   step_used;

  modport source (output valid, weight_out, step_used, input ready);
  modport sink   (input valid, weight_out, step_used, output ready);
endinterface

interface rbwb_cfg_if import rbwb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/radial_blend_weight_brush.sv @@
// Channel  Direction  Payload
// texel    in         texel_x, texel_y, layer_index, weight_in
// result   out        weight_out, step_used
// cfg      in         index, data (0 centre x, 1 centre y, 2 radius, 3 paint layer)
//
// One transaction per cycle in and out while the result side accepts; the pipeline
// depth depends on the coordinate and centre widths, set by the one-bit-per-stage square root.
// rst clears the stage valid bits and the configuration registers; no clearing pass.
// Each stage holds while its successor is full and stalled, so a stall on the
// result side fills bubbles first and drops or repeats nothing.
module radial_blend_weight_brush import rbwb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rbwb_in_if.sink    texel,
  rbwb_out_if.source result,
  rbwb_cfg_if.sink   cfg
);

  localparam int NST      = ROOT_W + 6;
  localparam int ST_DIST  = NST - 3;
  localparam int ST_STEP  = NST - 2;
  localparam int ST_OUT   = NST - 1;

  // Configuration registers
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic [RADIUS_W-1:0]        brush_radius;
  logic [LAYER_W-1:0]         paint_layer;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      brush_radius <= '0;
      paint_layer  <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_CENTER_X:     center_x     <= cfg.data;
        REG_CENTER_Y:     center_y     <= cfg.data;
        REG_BRUSH_RADIUS: brush_radius <= cfg.data[RADIUS_W-1:0];
        REG_PAINT_LAYER:  paint_layer  <= cfg.data[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when empty or when its successor loads
  logic [NST-1:0] vld;
  logic [NST:0]   go;
  logic [NST-1:0] vin;

  always_comb begin
    go[NST] = result.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
    vin[0] = texel.valid;
    for (int k = 1; k < NST; k++) begin
      vin[k] = vld[k-1];
    end
  end

  assign texel.ready = go[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (go[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: absolute coordinate differences
  logic [MAG_W-1:0]  tx_m, ty_m;
  logic [DIFF_W-1:0] dx, dy;
  logic [MAG_W-1:0]  adx, ady;
  logic [LAYER_W-1:0]  lay0, lay1;
  logic [WEIGHT_W-1:0] wgt0, wgt1;

  always_comb begin
    tx_m = MAG_W'(texel.texel_x) & COORD_MASK;
    ty_m = MAG_W'(texel.texel_y) & COORD_MASK;
    dx   = {1'b0, tx_m} - DIFF_W'(center_x);
    dy   = {1'b0, ty_m} - DIFF_W'(center_y);
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      adx  <= dx[DIFF_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      ady  <= dy[DIFF_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      lay0 <= texel.layer_index;
      wgt0 <= texel.weight_in;
    end
  end

  // Stage 1: squares
  logic [SQ_W-1:0] sqx, sqy;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      sqx  <= adx * adx;
      sqy  <= ady * ady;
      lay1 <= lay0;
      wgt1 <= wgt0;
    end
  end

  // Stage 2: sum of squares, seeding the root pipeline
  logic [RAD_W-1:0]    rad  [ROOT_W+1];
  logic [REM_W-1:0]    rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   root [ROOT_W+1];
  logic [LAYER_W-1:0]  lays [ROOT_W+1];
  logic [WEIGHT_W-1:0] wgts [ROOT_W+1];
  logic [SUM_W-1:0]    sq_sum;

  assign sq_sum = SUM_W'(sqx) + SUM_W'(sqy);

  always_ff @(posedge clk) begin
    if (go[2]) begin
      rad[0]  <= RAD_W'(sq_sum);
      rem[0]  <= '0;
      root[0] <= '0;
      lays[0] <= lay1;
      wgts[0] <= wgt1;
    end
  end

  // Root stages: one result bit each, restoring method
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb begin
      rem_sh = {rem[j][REM_W-3:0], rad[j][RAD_W-1 -: 2]};
      trial  = {root[j], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (go[3+j]) begin
        rad[j+1]  <= rad[j] << 2;
        lays[j+1] <= lays[j];
        wgts[j+1] <= wgts[j];
        if (rem_sh >= trial) begin
          rem[j+1]  <= rem_sh - trial;
          root[j+1] <= {root[j][ROOT_W-2:0], 1'b1};
        end else begin
          rem[j+1]  <= rem_sh;
          root[j+1] <= {root[j][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Round the root up where a remainder is left
  logic [DIST_W-1:0]   distance;
  logic [LAYER_W-1:0]  lay_d, lay_s;
  logic [WEIGHT_W-1:0] wgt_d, wgt_s;

  always_ff @(posedge clk) begin
    if (go[ST_DIST]) begin
      distance <= DIST_W'(root[ROOT_W]) + DIST_W'(rem[ROOT_W] != '0);
      lay_d    <= lays[ROOT_W];
      wgt_d    <= wgts[ROOT_W];
    end
  end

  // Step from distance: core, soft rings two units wide, then nothing
  logic [RADIUS_W-1:0] core;
  logic [RADIUS_W-1:0] rings;
  logic [DIST_W-1:0]   off;
  logic [RING_W-1:0]   ring;
  logic [STEP_W-1:0]   step_c;
  logic [STEP_W-1:0]   step;

  always_comb begin
    core  = brush_radius - (brush_radius >> 1);
    rings = brush_radius >> 2;
    off   = distance - DIST_W'(core) - DIST_W'(1);
    ring  = off[DIST_W-1:1];
    if (distance <= DIST_W'(core)) begin
      step_c = STEP_CORE;
    end else if (ring >= RING_W'(rings)) begin
      step_c = '0;
    end else begin
      step_c = ring_step(ring);
    end
  end

  always_ff @(posedge clk) begin
    if (go[ST_STEP]) begin
      step  <= step_c;
      lay_s <= lay_d;
      wgt_s <= wgt_d;
    end
  end

  // Output register: saturating gain on paint layer, loss elsewhere; layer >= 12 passes as is
  logic [WEIGHT_W:0]   w_up;
  logic [WEIGHT_W-1:0] w_new;
  logic [STEP_W-1:0]   step_new;
  logic                lay_ok;

  always_comb begin
    lay_ok = (5'(lay_s) < 5'(LAYER_COUNT));
    w_up   = (WEIGHT_W+1)'(wgt_s) + (WEIGHT_W+1)'(step);
    if (!lay_ok) begin
      w_new    = wgt_s;
      step_new = '0;
    end else if (lay_s == paint_layer) begin
      w_new    = w_up[WEIGHT_W] ? WEIGHT_MAX : w_up[WEIGHT_W-1:0];
      step_new = step;
    end else begin
      w_new    = (wgt_s < WEIGHT_W'(step)) ? '0 : wgt_s - WEIGHT_W'(step);
      step_new = step;
    end
  end

  always_ff @(posedge clk) begin
    if (go[ST_OUT]) begin
      result.weight_out <= w_new;
      result.step_used  <= step_new;
    end
  end

  assign result.valid = vld[ST_OUT];

endmodule
